>>> rtl/mwms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mwms_pkg;

  // Window length; the delay line has one entry per sample in the window.
  localparam int WINDOW = 16;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 24;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int SQ_W     = 39;
  localparam int SD_W     = 24;
  localparam int RAD_W    = 2 * SD_W;
  localparam int REM_W    = SD_W + 2;
  localparam int PTR_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int STEP_W   = (SD_W > 1) ? $clog2(SD_W) : 1;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;

  // Command to the sample history memory. Read and write address the same
  // entry: the oldest sample is read, then overwritten by the new one.
  typedef struct packed {
    logic                       rd_en;
    logic                       wr_en;
    logic [PTR_W-1:0]           addr;
    logic signed [SAMPLE_W-1:0] wr_data;
  } hist_cmd_t;

  typedef struct packed {
    logic             start;
    logic             ack;
    logic [RAD_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic            valid;
    logic [SD_W-1:0] root;
  } sqrt_rsp_t;

endpackage

`default_nettype wire

>>> rtl/mwms_hist.sv
`timescale 1ns / 1ps
`default_nettype none

module mwms_hist (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire mwms_pkg::hist_cmd_t                  cmd,
  output logic signed [mwms_pkg::SAMPLE_W-1:0]      rd_data
);

  logic signed [mwms_pkg::SAMPLE_W-1:0] mem [mwms_pkg::WINDOW];
  logic [mwms_pkg::WINDOW-1:0]          written_r;
  logic signed [mwms_pkg::SAMPLE_W-1:0] rd_word_r;
  logic                                 rd_written_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rd_word_r <= mem[cmd.addr];
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r    <= '0;
      rd_written_r <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        written_r[cmd.addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_written_r <= written_r[cmd.addr];
      end
    end
  end

  assign rd_data = rd_written_r ? rd_word_r : '0;

endmodule

`default_nettype wire

>>> rtl/mwms_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module mwms_isqrt (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mwms_pkg::sqrt_req_t req,
  output mwms_pkg::sqrt_rsp_t      rsp
);

  localparam int RW = mwms_pkg::REM_W;

  logic                          busy_r;
  logic                          valid_r;
  logic [mwms_pkg::STEP_W-1:0]   step_r;
  logic [mwms_pkg::RAD_W-1:0]    rad_r;
  logic [RW-1:0]                 rem_r;
  logic [mwms_pkg::SD_W-1:0]     root_r;

  logic [RW+1:0] rem_shift;
  logic [RW+1:0] trial;
  logic          fits;

  // One result bit per cycle: bring down two radicand bits, try 4*root+1.
  assign rem_shift = {rem_r, rad_r[mwms_pkg::RAD_W-1 -: 2]};
  assign trial     = {2'b00, root_r, 2'b01};
  assign fits      = (rem_shift >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else if (req.start) begin
      busy_r  <= 1'b1;
      valid_r <= 1'b0;
    end else if (busy_r && step_r == '0) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b1;
    end else if (req.ack) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rad_r  <= req.radicand;
      rem_r  <= '0;
      root_r <= '0;
      step_r <= mwms_pkg::STEP_W'(mwms_pkg::SD_W - 1);
    end else if (busy_r) begin
      rad_r  <= {rad_r[mwms_pkg::RAD_W-3:0], 2'b00};
      rem_r  <= fits ? RW'(rem_shift - trial) : RW'(rem_shift);
      root_r <= {root_r[mwms_pkg::SD_W-2:0], fits};
      step_r <= step_r - 1'b1;
    end
  end

  assign rsp.valid = valid_r;
  assign rsp.root  = root_r;

endmodule

`default_nettype wire

>>> rtl/moving_window_mean_stddev.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  tdata (low bit first)                      tuser / tlast
// in_      slave      [15:0] sample (signed)                      none
// out_     master     [23:0] window_sum (signed),                 none
//                     [47:24] scaled_stddev (unsigned)
//
// One sample is processed at a time. On acceptance the history entry is read;
// then the running sum is updated, then the sum of squares and the squared
// sum, then the radicand is formed and passed to the square-root unit, which
// produces one root bit per cycle and sets the rate, and its result is loaded
// into the output register. The next beat can be accepted in the cycle after
// the load, so a new sample is not taken before the last result is loaded.
// Reset clears the sample history through per-entry written flags, so no
// clearing pass is needed. The next sample is taken while a finished result
// still waits in the output register; a result only stalls the block if the
// output register is still full when the next root is ready.

module moving_window_mean_stddev (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [mwms_pkg::IN_TDATA_W-1:0]      in_tdata,   // [15:0] sample
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [mwms_pkg::OUT_TDATA_W-1:0]          out_tdata   // [23:0] window_sum,
                                                                // [47:24] scaled_stddev
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_SQSUM = 5'b00100,
    S_NUM   = 5'b01000,
    S_ROOT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [mwms_pkg::PTR_W-1:0]           ptr_r;
  logic signed [mwms_pkg::SAMPLE_W-1:0] x_r;
  logic [mwms_pkg::PROD_W-1:0]          new_sq_r;
  logic [mwms_pkg::PROD_W-1:0]          old_sq_r;
  logic signed [mwms_pkg::SUM_W-1:0]    sum_r;
  logic [mwms_pkg::SQ_W-1:0]            sumsq_r;
  logic [mwms_pkg::RAD_W-1:0]           mag_sq_r;

  logic                                 out_valid_r;
  logic [mwms_pkg::SUM_W-1:0]           out_sum_r;
  logic [mwms_pkg::SD_W-1:0]            out_sd_r;

  logic signed [mwms_pkg::SAMPLE_W-1:0] sample;
  logic signed [mwms_pkg::SAMPLE_W-1:0] old_sample;
  logic signed [mwms_pkg::PROD_W-1:0]   old_prod;
  logic signed [mwms_pkg::PROD_W-1:0]   new_prod;
  logic [mwms_pkg::SUM_W-1:0]           mag;
  logic [mwms_pkg::RAD_W-1:0]           scaled_sumsq;
  logic                                 in_beat;
  logic                                 out_free;
  logic                                 load_out;

  mwms_pkg::hist_cmd_t hist_cmd;
  mwms_pkg::sqrt_req_t sq_req;
  mwms_pkg::sqrt_rsp_t sq_rsp;

  assign sample    = $signed(in_tdata[mwms_pkg::SAMPLE_W-1:0]);
  assign in_tready = (state_r == S_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign load_out  = (state_r == S_ROOT) && sq_rsp.valid && out_free;

  // The oldest entry is read on acceptance and overwritten the next cycle.
  assign hist_cmd.rd_en   = in_beat;
  assign hist_cmd.wr_en   = (state_r == S_READ);
  assign hist_cmd.addr    = ptr_r;
  assign hist_cmd.wr_data = x_r;

  mwms_hist u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (hist_cmd),
    .rd_data (old_sample)
  );

  assign new_prod = mwms_pkg::PROD_W'(sample) * mwms_pkg::PROD_W'(sample);
  assign old_prod = mwms_pkg::PROD_W'(old_sample) * mwms_pkg::PROD_W'(old_sample);

  // Magnitude of the window sum; the most negative sum maps to 2^23 unsigned.
  assign mag = sum_r[mwms_pkg::SUM_W-1] ? (~sum_r + 1'b1) : sum_r;

  // WINDOW * sum of squares minus sum squared is never negative.
  assign scaled_sumsq = mwms_pkg::RAD_W'(sumsq_r) * mwms_pkg::RAD_W'(mwms_pkg::WINDOW);

  assign sq_req.start    = (state_r == S_NUM);
  assign sq_req.ack      = load_out;
  assign sq_req.radicand = scaled_sumsq - mag_sq_r;

  mwms_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sq_req),
    .rsp   (sq_rsp)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_beat) begin
        state_nxt = S_READ;
      end
      S_READ:  state_nxt = S_SQSUM;
      S_SQSUM: state_nxt = S_NUM;
      S_NUM:   state_nxt = S_ROOT;
      S_ROOT:  if (load_out) begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      sum_r       <= '0;
      sumsq_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_READ) begin
        sum_r <= sum_r - mwms_pkg::SUM_W'(old_sample) + mwms_pkg::SUM_W'(x_r);
        if (ptr_r == mwms_pkg::PTR_W'(mwms_pkg::WINDOW - 1)) begin
          ptr_r <= '0;
        end else begin
          ptr_r <= ptr_r + 1'b1;
        end
      end
      if (state_r == S_SQSUM) begin
        sumsq_r <= sumsq_r - mwms_pkg::SQ_W'(old_sq_r) + mwms_pkg::SQ_W'(new_sq_r);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      x_r      <= sample;
      new_sq_r <= $unsigned(new_prod);
    end
    if (state_r == S_READ) begin
      old_sq_r <= $unsigned(old_prod);
    end
    if (state_r == S_SQSUM) begin
      mag_sq_r <= mwms_pkg::RAD_W'(mag) * mwms_pkg::RAD_W'(mag);
    end
    if (load_out) begin
      out_sum_r <= sum_r;
      out_sd_r  <= sq_rsp.root;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_sd_r, out_sum_r};

`ifndef SYNTHESIS
  a_root_only_in_root_state: assert property (@(posedge clk) disable iff (!rst_n)
    sq_rsp.valid |-> state_r == S_ROOT)
    else $error("square-root result present outside the root state");

  a_accept_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_READ && hist_cmd.wr_en)
    else $error("accepted beat did not proceed to the history update");

  a_ptr_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= mwms_pkg::PTR_W'(mwms_pkg::WINDOW - 1))
    else $error("history pointer beyond the window");

  a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_tvalid && state_r == S_IDLE)
    else $error("finished result not presented on the output");
`endif

endmodule

`default_nettype wire

>>> test/moving_window_mean_stddev_tb.sv
`timescale 1ns / 1ps

// Checks the moving-window sum and scaled standard deviation block. Samples are
// streamed into the slave channel. Each accepted beat is run through a local
// predictor that keeps its own delay line and running sums. The predicted
// result is queued and compared, field by field, against the next result beat.
module moving_window_mean_stddev_tb;
  import mwms_pkg::*;

  // Slowest correct run: a long sender gap, the time spent in the block and a
  // long receiver stall per sample, for each of ~1800 samples.
  // The limit leaves a wide margin over that.
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1700;
  localparam int TAIL_CYCLES  = 40;

  typedef struct packed {
    logic signed [SUM_W-1:0] window_sum;
    logic [SD_W-1:0]         scaled_stddev;
  } window_stats_t;

  // Kinds of random runs. Each run of samples follows one of these patterns.
  typedef enum int {
    RUN_ANY,
    RUN_SMALL,
    RUN_EXTREME,
    RUN_CONSTANT,
    RUN_ALTERNATE
  } sample_run_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Local copy of the block's state.
  logic signed [SAMPLE_W-1:0] history [WINDOW];
  logic signed [SUM_W-1:0]    window_total = '0;
  logic [SQ_W-1:0]            square_total = '0;
  logic [PTR_W-1:0]           oldest_slot = '0;

  window_stats_t expected_stats[$];
  int            fail_count = 0;
  int            cycle_count = 0;
  // When set, neither side inserts gaps or stalls.
  bit            no_idle = 1'b0;

  moving_window_mean_stddev DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [15:0] sample
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)    // [23:0] window_sum, [47:24] scaled_stddev
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < WINDOW; i++) begin
      history[i] = '0;
    end
  end

  // Mostly short pauses, now and then a long one.
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(16, 48);
  endfunction

  // Feeds one sample into the local delay line and queues the sum and the
  // integer square root of WINDOW * sum of squares - sum^2.
  function automatic void predict_window_stats(logic signed [SAMPLE_W-1:0] x);
    logic signed [SAMPLE_W-1:0] evicted;
    longint signed              total;
    longint unsigned            spread;
    longint unsigned            root;
    longint unsigned            trial;
    int                         b;
    evicted = history[oldest_slot];
    history[oldest_slot] = x;
    window_total = window_total - evicted + x;
    square_total = square_total - longint'(evicted) * longint'(evicted)
                   + longint'(x) * longint'(x);
    oldest_slot = (oldest_slot == PTR_W'(WINDOW - 1)) ? '0 : oldest_slot + 1'b1;
    total = window_total;
    spread = longint'(WINDOW) * longint'(square_total) - total * total;
    // Build the root one bit at a time from the top, keeping a bit whenever
    // its square still fits under the spread.
    root = 0;
    for (b = SD_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= spread) begin
        root = trial;
      end
    end
    expected_stats.push_back('{window_total, root[SD_W-1:0]});
  endfunction

  // Sends one sample beat after a random gap and predicts its result once it
  // is accepted. Valid stays high afterwards so back-to-back beats need no
  // extra assignment; the caller lowers it when the stream ends.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 99) >= 65) begin
      gap = pick_pause();
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= x;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_window_stats(x);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] draw_sample(
      input sample_run_t kind, input int idx, input logic signed [SAMPLE_W-1:0] base);
    int t;
    case (kind)
      RUN_SMALL: begin
        t = int'($urandom_range(0, 512)) - 256;
        return t[SAMPLE_W-1:0];
      end
      RUN_EXTREME: begin
        if ($urandom_range(0, 1)) begin
          t = -32768 + int'($urandom_range(0, 15));
        end else begin
          t = 32767 - int'($urandom_range(0, 15));
        end
        return t[SAMPLE_W-1:0];
      end
      RUN_CONSTANT: return base;
      // Flipping every bit of the base makes each bit toggle within the run.
      RUN_ALTERNATE: return idx[0] ? base : ~base;
      default: return SAMPLE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // The first windows after reset still count the cleared zeros.
  task automatic test_warmup();
    send_sample(16'sh7fff);
    send_sample(-16'sh8000);
    send_sample(-16'sd1);
    send_sample(16'sd1);
  endtask

  // A full window of the most negative sample: the sum hits its low end and
  // the deviation must come out as exactly zero.
  task automatic test_constant_window();
    repeat (WINDOW) send_sample(-16'sh8000);
  endtask

  // Positive full scale pushed into a window of negative full scale.
  task automatic test_extremes();
    send_sample(16'sh7fff);
    send_sample(-16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'sh7fff);
    send_sample(16'sh0000);
  endtask

  // The sender goes quiet until every result is out, then resumes at full rate.
  task automatic test_drain_pause();
    repeat (20) send_sample(draw_sample(RUN_ANY, 0, '0));
    in_tvalid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
    no_idle = 1'b1;
    repeat (20) send_sample(draw_sample(RUN_ANY, 0, '0));
    no_idle = 1'b0;
  endtask

  // Runs of random length, each with its own value pattern; about one run in
  // five goes without any idling on either side.
  task automatic test_random_runs();
    int                         sent;
    int                         run_len;
    sample_run_t                kind;
    logic signed [SAMPLE_W-1:0] base;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      kind = sample_run_t'($urandom_range(0, 4));
      run_len = $urandom_range(10, 60);
      if ($urandom_range(0, 1)) begin
        base = SAMPLE_W'($urandom_range(0, 65535));
      end else begin
        base = $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
      end
      no_idle = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < run_len; i++) begin
        send_sample(draw_sample(kind, i, base));
      end
      sent += run_len;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_warmup();
    test_constant_window();
    test_extremes();
    test_drain_pause();
    test_random_runs();
    in_tvalid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
    // Extra cycles catch any result beat that nothing asked for.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_stats.size() == 0) begin
      $display("moving_window_mean_stddev regression: pass");
    end else begin
      $display("moving_window_mean_stddev regression: fail");
    end
    $finish;
  end

  // Receiver back-pressure: ready most of the time, with stalls of random
  // length in between.
  initial begin : drive_ready
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 99) >= 70) begin
        stall_left = pick_pause() - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Handshake values are read right at the edge, before any nonblocking
  // update of that edge lands, so they are the values the block saw.
  always @(posedge clk) begin : check_results
    window_stats_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_stats.size() == 0) begin
        $error("result beat with no sample waiting: window_sum %0d, scaled_stddev %0d",
               $signed(out_tdata[SUM_W-1:0]), out_tdata[SUM_W +: SD_W]);
        fail_count++;
      end else begin
        want = expected_stats.pop_front();
        if (out_tdata[SUM_W-1:0] !== want.window_sum) begin
          $error("window_sum: expected %0d, got %0d",
                 want.window_sum, $signed(out_tdata[SUM_W-1:0]));
          fail_count++;
        end
        if (out_tdata[SUM_W +: SD_W] !== want.scaled_stddev) begin
          $error("scaled_stddev: expected %0d, got %0d",
                 want.scaled_stddev, out_tdata[SUM_W +: SD_W]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("moving_window_mean_stddev regression: fail");
      $finish;
    end
  end

endmodule

>>> moving_window_mean_stddev.f
rtl/mwms_pkg.sv
rtl/mwms_hist.sv
rtl/mwms_isqrt.sv
rtl/moving_window_mean_stddev.sv
test/moving_window_mean_stddev_tb.sv
